FILE: src/pixelwise_multiply_scale_unit_assert.svh
// Assertion macros shared by the pixelwise multiply scale unit
`ifndef PIXELWISE_MULTIPLY_SCALE_UNIT_ASSERT_SVH
`define PIXELWISE_MULTIPLY_SCALE_UNIT_ASSERT_SVH

// Overlapping implication, sampled on clk, off while rst_n is low
`define PMSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PMSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pmsu_pkg.sv
// Shared types and constants for the pixelwise multiply scale unit
package pmsu_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned OPND_W   = 17;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    // type_mode codes
    localparam logic [2:0] MODE_U8U8_U8   = 3'd0;
    localparam logic [2:0] MODE_S16S16    = 3'd1;
    localparam logic [2:0] MODE_S16U8     = 3'd2;
    localparam logic [2:0] MODE_U8S16     = 3'd3;
    localparam logic [2:0] MODE_U8U8_S16  = 3'd4;
    localparam logic [2:0] MODE_RSVD_5    = 3'd5;
    localparam logic [2:0] MODE_RSVD_6    = 3'd6;
    localparam logic [2:0] MODE_RSVD_7    = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SCALE_255 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATE      = 2'd3;

    // floor(2^39 / 255): t / 255 for t below 2^31 is (t * RECIP_255) >> 39, low by at most one
    localparam logic [31:0] RECIP_255   = 32'h8080_8080;
    localparam int unsigned RECIP_SHIFT = 39;
    localparam logic [31:0] DIV_255     = 32'd255;

    typedef struct packed {
        logic [2:0] type_mode;
        logic       use_scale_255;
        logic [3:0] shift_amount;
        logic       saturate;
    } cfg_t;

endpackage

FILE: src/pmsu_mult.sv
// Operand decode and signed product stages
module pmsu_mult
    import pmsu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    input  logic [2:0]               type_mode,
    output logic                     prod_valid,
    output logic signed [PROD_W-1:0] prod
);

    logic                     dec_valid_reg;
    logic signed [OPND_W-1:0] x_reg;
    logic signed [OPND_W-1:0] y_reg;
    logic signed [OPND_W-1:0] x_next;
    logic signed [OPND_W-1:0] y_next;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [2*OPND_W-1:0] full_prod;

    // u8 roles take the low byte unsigned, s16 roles sign-extend
    always_comb
    begin
        case (type_mode)
            MODE_S16S16:
            begin
                x_next = {operand_a[DATA_W-1], operand_a};
                y_next = {operand_b[DATA_W-1], operand_b};
            end
            MODE_S16U8:
            begin
                x_next = {operand_a[DATA_W-1], operand_a};
                y_next = {9'd0, operand_b[7:0]};
            end
            MODE_U8S16:
            begin
                x_next = {9'd0, operand_a[7:0]};
                y_next = {operand_b[DATA_W-1], operand_b};
            end
            default:
            begin
                x_next = {9'd0, operand_a[7:0]};
                y_next = {9'd0, operand_b[7:0]};
            end
        endcase
    end

    assign full_prod = x_reg * y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            dec_valid_reg  <= in_valid;
            prod_valid_reg <= dec_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        // magnitude never exceeds 2^30, so 32 bits hold it
        prod_reg <= full_prod[PROD_W-1:0];
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

FILE: src/pmsu_scale.sv
// Scaling stages: shift toward zero, or divide by 255 as trunc((2p + 255) / 510), half up for p >= 0
module pmsu_scale
    import pmsu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     prod_valid,
    input  logic signed [PROD_W-1:0] prod,
    input  logic                     use_scale_255,
    input  logic [3:0]               shift_amount,
    output logic                     scl_valid,
    output logic signed [PROD_W-1:0] scaled
);

    // stage A: magnitudes and the shift result
    logic signed [PROD_W:0]   v_a;
    logic [PROD_W:0]          vmag_a;
    logic [PROD_W-1:0]        pmag_a;
    logic [PROD_W-1:0]        sh_a;
    logic signed [PROD_W-1:0] shs_next;
    logic                     a_valid_reg;
    logic [30:0]              t_a_reg;
    logic                     neg_a_reg;
    logic signed [PROD_W-1:0] sh_a_reg;

    // stage B: reciprocal multiply
    logic [62:0]              recip_prod;
    logic                     b_valid_reg;
    logic [23:0]              q0_b_reg;
    logic [30:0]              t_b_reg;
    logic                     neg_b_reg;
    logic signed [PROD_W-1:0] sh_b_reg;

    // stage C: correct the quotient and select
    logic [PROD_W-1:0]        q0x255;
    logic [PROD_W-1:0]        rem;
    logic [PROD_W-1:0]        q_fix;
    logic signed [PROD_W-1:0] sdiv;
    logic signed [PROD_W-1:0] scaled_next;
    logic                     c_valid_reg;
    logic signed [PROD_W-1:0] scaled_reg;

    // trunc((2p + 255) / 510) = sign * floor((|2p + 255| >> 1) / 255)
    assign v_a    = {prod, 1'b0} + (PROD_W+1)'(255);
    assign vmag_a = v_a[PROD_W] ? (~v_a + 1'b1) : v_a;
    assign pmag_a = prod[PROD_W-1] ? (~prod + 1'b1) : prod;
    assign sh_a   = pmag_a >> shift_amount;
    assign shs_next = prod[PROD_W-1] ? $signed(~sh_a + 1'b1) : $signed(sh_a);

    assign recip_prod = t_a_reg * RECIP_255;

    assign q0x255 = {q0_b_reg, 8'd0} - {8'd0, q0_b_reg};
    assign rem    = {1'b0, t_b_reg} - q0x255;
    assign q_fix  = {8'd0, q0_b_reg} + {31'd0, (rem >= DIV_255)};
    assign sdiv   = neg_b_reg ? $signed(~q_fix + 1'b1) : $signed(q_fix);
    assign scaled_next = use_scale_255 ? sdiv : sh_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= prod_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_a_reg    <= vmag_a[31:1];
        neg_a_reg  <= v_a[PROD_W];
        sh_a_reg   <= shs_next;
        q0_b_reg   <= recip_prod[62:RECIP_SHIFT];
        t_b_reg    <= t_a_reg;
        neg_b_reg  <= neg_a_reg;
        sh_b_reg   <= sh_a_reg;
        scaled_reg <= scaled_next;
    end

    assign scl_valid = c_valid_reg;
    assign scaled    = scaled_reg;

endmodule

FILE: src/pmsu_narrow.sv
// Output narrowing stage: saturate or wrap to the output type, zero for reserved modes
module pmsu_narrow
    import pmsu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     scl_valid,
    input  logic signed [PROD_W-1:0] scaled,
    input  logic [2:0]               type_mode,
    input  logic                     saturate,
    output logic                     done,
    output logic signed [DATA_W-1:0] product_out
);

    logic                     done_reg;
    logic signed [DATA_W-1:0] out_reg;
    logic signed [DATA_W-1:0] out_next;
    logic signed [DATA_W-1:0] s16_sat;
    logic [7:0]               u8_sat;

    always_comb
    begin
        if (scaled > 32'sd32767)
            s16_sat = 16'sh7FFF;
        else if (scaled < -32'sd32768)
            s16_sat = 16'sh8000;
        else
            s16_sat = scaled[DATA_W-1:0];
    end

    // u8 products are never negative
    assign u8_sat = (scaled > 32'sd255) ? 8'hFF : scaled[7:0];

    always_comb
    begin
        case (type_mode)
            MODE_U8U8_U8:
                out_next = saturate ? {8'd0, u8_sat} : {8'd0, scaled[7:0]};
            MODE_S16S16, MODE_S16U8, MODE_U8S16, MODE_U8U8_S16:
                out_next = saturate ? s16_sat : scaled[DATA_W-1:0];
            default:
                out_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= scl_valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done        = done_reg;
    assign product_out = out_reg;

endmodule

FILE: src/pixelwise_multiply_scale_unit.sv
// Top level of the pixelwise multiply scale unit: config registers and pipeline
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------
//  input     start & !busy        operand_a, operand_b
//  result    done (one cycle)     product_out
//  config    cfg_we               cfg_index, cfg_data
//
// Six register stages: decode, 17x17 multiply, scale prep, 31x32 reciprocal
// multiply, quotient fix and select, narrow. One item is taken every cycle.
// busy is always low: the pipeline has no stall path since the receiver
// cannot hold results off.
// rst_n clears the valid bits and the config registers at once.
module pixelwise_multiply_scale_unit
    import pmsu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output logic                     done,
    output logic signed [DATA_W-1:0] product_out,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    `include "pixelwise_multiply_scale_unit_assert.svh"

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    logic                     prod_valid;
    logic signed [PROD_W-1:0] prod;
    logic                     scl_valid;
    logic signed [PROD_W-1:0] scaled;

    assign busy = 1'b0;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TYPE_MODE:     cfg_next.type_mode     = cfg_data[2:0];
                REG_USE_SCALE_255: cfg_next.use_scale_255 = cfg_data[0];
                REG_SHIFT_AMOUNT:  cfg_next.shift_amount  = cfg_data[3:0];
                REG_SATURATE:      cfg_next.saturate      = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pmsu_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .type_mode  (cfg_reg.type_mode),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    pmsu_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .prod_valid    (prod_valid),
        .prod          (prod),
        .use_scale_255 (cfg_reg.use_scale_255),
        .shift_amount  (cfg_reg.shift_amount),
        .scl_valid     (scl_valid),
        .scaled        (scaled)
    );

    pmsu_narrow u_narrow (
        .clk         (clk),
        .rst_n       (rst_n),
        .scl_valid   (scl_valid),
        .scaled      (scaled),
        .type_mode   (cfg_reg.type_mode),
        .saturate    (cfg_reg.saturate),
        .done        (done),
        .product_out (product_out)
    );

    `PMSU_ASSERT_IMP(a_done_follows_transfer, start && !busy, ##6 done,
        "transfer did not produce a result six cycles later")
    `PMSU_ASSERT_IMP(a_no_phantom_done, !(start && !busy), ##6 !done,
        "result strobe without a matching transfer")
    `PMSU_ASSERT_NEXT(a_u8_range, scl_valid && cfg_reg.type_mode == MODE_U8U8_U8,
        product_out[15:8] == 8'd0, "u8 output mode produced a value above 255")
    `PMSU_ASSERT_NEXT(a_reserved_zero,
        scl_valid && (cfg_reg.type_mode == MODE_RSVD_5 || cfg_reg.type_mode == MODE_RSVD_6
        || cfg_reg.type_mode == MODE_RSVD_7),
        product_out == 16'sd0, "reserved type mode produced a nonzero result")

endmodule

FILE: verif/pixelwise_multiply_scale_unit_checker.sv
// Checker for the pixelwise multiply scale unit: tracks config, predicts and compares products
module pixelwise_multiply_scale_unit_checker
    import pmsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [DATA_W-1:0]     operand_a,
    input  logic [DATA_W-1:0]     operand_b,
    input  logic                  done,
    input  logic [DATA_W-1:0]     product_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    outstanding,
    output int                    mismatches
);

    localparam longint S16_MAX = 32767;
    localparam longint S16_MIN = -32768;
    localparam longint U8_MAX  = 255;

    typedef struct {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] product;
    } product_entry_t;

    cfg_t           settings;
    product_entry_t pending_products [$];
    int             error_count = 0;

    assign mismatches = error_count;

    function automatic logic [DATA_W-1:0] predict_scaled_product(
        input cfg_t c, input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        longint      x;
        longint      y;
        longint      prod;
        longint      scaled;
        logic [63:0] bits;
        logic [15:0] low;
        case (c.type_mode)
            MODE_U8U8_U8, MODE_U8U8_S16:
            begin
                x = longint'(a[7:0]);
                y = longint'(b[7:0]);
            end
            MODE_S16S16:
            begin
                x = longint'($signed(a));
                y = longint'($signed(b));
            end
            MODE_S16U8:
            begin
                x = longint'($signed(a));
                y = longint'(b[7:0]);
            end
            MODE_U8S16:
            begin
                x = longint'(a[7:0]);
                y = longint'($signed(b));
            end
            default:
                return '0;
        endcase
        prod = x * y;
        // 1/255 exact as (2p + 255) / 510 truncated toward zero, round half up for p >= 0
        if (c.use_scale_255)
            scaled = (2 * prod + 255) / 510;
        else if (prod < 0)
            scaled = -((-prod) >> c.shift_amount);
        else
            scaled = prod >> c.shift_amount;
        bits = scaled;
        low  = bits[15:0];
        case (c.type_mode)
            MODE_U8U8_U8:
                if (c.saturate)
                    return (low > U8_MAX) ? DATA_W'(U8_MAX) : low;
                else
                    return {8'd0, low[7:0]};
            MODE_U8U8_S16:
                if (c.saturate && low > S16_MAX)
                    return DATA_W'(S16_MAX);
                else
                    return low;
            default:
            begin
                if (c.saturate)
                begin
                    if (scaled > S16_MAX)
                        scaled = S16_MAX;
                    if (scaled < S16_MIN)
                        scaled = S16_MIN;
                end
                bits = scaled;
                return bits[15:0];
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t checker: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_entry_t entry;
        if (!rst_n)
        begin
            settings <= '0;
            pending_products.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_products.size() == 0)
                    flag_mismatch($sformatf("product %h with no transfer waiting", product_out));
                else
                begin
                    entry = pending_products.pop_front();
                    if (product_out !== entry.product)
                        flag_mismatch($sformatf(
                            "a=%h b=%h mode=%0d s255=%0d sh=%0d sat=%0d: got %h, want %h",
                            entry.a, entry.b, settings.type_mode, settings.use_scale_255,
                            settings.shift_amount, settings.saturate, product_out,
                            entry.product));
                end
            end
            if (start && !busy)
            begin
                entry.a       = operand_a;
                entry.b       = operand_b;
                entry.product = predict_scaled_product(settings, operand_a, operand_b);
                pending_products.push_back(entry);
            end
            // upper data bits beyond a register's width are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TYPE_MODE:     settings.type_mode     <= cfg_data[2:0];
                    REG_USE_SCALE_255: settings.use_scale_255 <= cfg_data[0];
                    REG_SHIFT_AMOUNT:  settings.shift_amount  <= cfg_data[3:0];
                    REG_SATURATE:      settings.saturate      <= cfg_data[0];
                    default: ;
                endcase
            end
            outstanding <= pending_products.size();
        end
    end

endmodule

FILE: verif/pixelwise_multiply_scale_unit_tb.sv
// Testbench top for the pixelwise multiply scale unit: stimulus, config phases and verdict
module pixelwise_multiply_scale_unit_tb;
    import pmsu_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_SLACK     = 10;
    localparam int RANDOM_PHASES   = 24;
    localparam int PAIRS_PER_PHASE = 75;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [DATA_W-1:0]     operand_a;
    logic [DATA_W-1:0]     operand_b;
    logic                  done;
    logic [DATA_W-1:0]     product_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    outstanding;
    int                    mismatches;

    always #4 clk = ~clk;

    pixelwise_multiply_scale_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .done        (done),
        .product_out (product_out),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    pixelwise_multiply_scale_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .done        (done),
        .product_out (product_out),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Hold the pair until a transfer happens
    task automatic push_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until every expected product is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        logic [CFG_IDX_W-1:0]  reg_order [4];
        logic [CFG_DATA_W-1:0] reg_data  [4];
        reg_order = '{REG_TYPE_MODE, REG_USE_SCALE_255, REG_SHIFT_AMOUNT, REG_SATURATE};
        // junk in the unused upper data bits must be ignored
        reg_data[0] = {1'($urandom_range(0, 1)), c.type_mode};
        reg_data[1] = {3'($urandom_range(0, 7)), c.use_scale_255};
        reg_data[2] = c.shift_amount;
        reg_data[3] = {3'($urandom_range(0, 7)), c.saturate};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= reg_data[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed(input logic [2:0] mode, input logic scale_255,
                                input logic [3:0] shift, input logic sat,
                                input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        cfg_t c;
        c = '{type_mode: mode, use_scale_255: scale_255, shift_amount: shift, saturate: sat};
        apply_settings(c);
        push_pair(a, b);
        wait_drained();
    endtask

    function automatic cfg_t random_settings(input int phase);
        cfg_t c;
        if (phase < 5)
            c.type_mode = 3'(phase);
        else if ($urandom_range(0, 9) == 0)
            c.type_mode = 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
        else
            c.type_mode = 3'($urandom_range(MODE_U8U8_U8, MODE_U8U8_S16));
        c.use_scale_255 = ($urandom_range(0, 3) == 0);
        case (phase % 4)
            0:       c.shift_amount = 4'd0;
            1:       c.shift_amount = 4'd15;
            default: c.shift_amount = 4'($urandom_range(0, 15));
        endcase
        c.saturate = 1'(phase >> 1);
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] random_operand();
        logic [DATA_W-1:0] corners [8];
        corners = '{16'h0000, 16'h0001, 16'h00FF, 16'h0080,
                    16'h7FFF, 16'h8000, 16'hFFFF, 16'hFF00};
        case ($urandom_range(0, 7))
            0:       return corners[$urandom_range(0, 7)];
            1:       return DATA_W'($urandom_range(0, 63)) - DATA_W'(32);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("pixelwise_multiply_scale_unit_tb: errors");
        $finish;
    end

    initial
    begin
        cfg_t settings;
        int   burst_left;
        int   gap;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operand_a  = '0;
        operand_b  = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_TYPE_MODE;
        cfg_data   = '0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unsigned products: saturate, wrap, 1/255, deepest shift
        run_directed(MODE_U8U8_U8, 1'b0, 4'd0, 1'b1, 16'hFFFF, 16'hFFFF);
        run_directed(MODE_U8U8_U8, 1'b0, 4'd0, 1'b0, 16'h00FF, 16'h00FF);
        run_directed(MODE_U8U8_U8, 1'b1, 4'd0, 1'b0, 16'h00FF, 16'h00FF);
        run_directed(MODE_U8U8_U8, 1'b0, 4'd15, 1'b1, 16'h00FF, 16'h00FF);
        run_directed(MODE_U8U8_U8, 1'b0, 4'd8, 1'b0, 16'hAAFF, 16'h55FF);
        // signed corners and rounding toward zero
        run_directed(MODE_S16S16, 1'b0, 4'd0, 1'b1, 16'h8000, 16'h8000);
        run_directed(MODE_S16S16, 1'b0, 4'd0, 1'b0, 16'h8000, 16'h7FFF);
        run_directed(MODE_S16S16, 1'b0, 4'd15, 1'b1, 16'h8000, 16'h8000);
        run_directed(MODE_S16S16, 1'b0, 4'd15, 1'b0, 16'h8000, 16'h7FFF);
        run_directed(MODE_S16S16, 1'b0, 4'd1, 1'b0, 16'hFFFF, 16'h0001);
        run_directed(MODE_S16S16, 1'b1, 4'd0, 1'b1, 16'h8000, 16'h8000);
        run_directed(MODE_S16S16, 1'b1, 4'd0, 1'b0, 16'hFFFF, 16'hFF80);
        run_directed(MODE_S16S16, 1'b1, 4'd0, 1'b0, 16'hFF81, 16'h0001);
        run_directed(MODE_S16S16, 1'b0, 4'd0, 1'b0, 16'h0000, 16'h0000);
        run_directed(MODE_S16S16, 1'b0, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF);
        // mixed signedness
        run_directed(MODE_S16U8, 1'b0, 4'd4, 1'b1, 16'h8000, 16'hFFFF);
        run_directed(MODE_S16U8, 1'b1, 4'd0, 1'b0, 16'h7FFF, 16'h12FF);
        run_directed(MODE_U8S16, 1'b0, 4'd0, 1'b0, 16'hFF80, 16'h8000);
        run_directed(MODE_U8S16, 1'b1, 4'd0, 1'b1, 16'h00FF, 16'h8000);
        // unsigned product into a signed result
        run_directed(MODE_U8U8_S16, 1'b0, 4'd0, 1'b1, 16'h00FF, 16'h00FF);
        run_directed(MODE_U8U8_S16, 1'b0, 4'd0, 1'b0, 16'h80FF, 16'h7FFF);
        run_directed(MODE_U8U8_S16, 1'b1, 4'd0, 1'b1, 16'h00FF, 16'h00FF);
        // reserved type codes give zero
        run_directed(MODE_RSVD_5, 1'b0, 4'd0, 1'b0, 16'h7FFF, 16'h7FFF);
        run_directed(MODE_RSVD_6, 1'b1, 4'd3, 1'b1, 16'h8000, 16'hFFFF);
        run_directed(MODE_RSVD_7, 1'b0, 4'd15, 1'b1, 16'hFFFF, 16'h8000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settings = random_settings(phase);
            apply_settings(settings);
            for (int i = 0; i < PAIRS_PER_PHASE; i++)
            begin
                push_pair(random_operand(), random_operand());
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(0, 20);
                end
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("pixelwise_multiply_scale_unit_tb: clean");
        else
            $display("pixelwise_multiply_scale_unit_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/pmsu_pkg.sv
src/pmsu_mult.sv
src/pmsu_scale.sv
src/pmsu_narrow.sv
src/pixelwise_multiply_scale_unit.sv
verif/pixelwise_multiply_scale_unit_checker.sv
verif/pixelwise_multiply_scale_unit_tb.sv
